FILE: src/tfc_pkg.sv
// Shared types, constants and the segment table for the thermistor filter
// with focuser temperature compensation. No dependencies.
package tfc_pkg;

  localparam int SampleW = 10;
  localparam int FiltW   = 14;
  localparam int RegW    = 16;
  localparam int TempW   = 12;
  localparam int MulW    = 16;
  localparam int CntW    = $clog2(MulW);
  localparam int IdxW    = 2;

  localparam logic [SampleW-1:0] SampleHigh = 10'h3F0;
  localparam logic [SampleW-1:0] SampleLow  = 10'h010;

  // Register indexes of the configuration port
  localparam logic [IdxW-1:0] RegCoef     = 2'd0;
  localparam logic [IdxW-1:0] RegBasePos  = 2'd1;
  localparam logic [IdxW-1:0] RegBaseTemp = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_MUL1,
    ST_TEMP,
    ST_COMP,
    ST_MUL2,
    ST_POS,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic        [8:0]      slope;
    logic signed [RegW-1:0] icpt;
    logic        [9:0]      offs;
  } seg_t;

  // Three-segment piecewise-linear curve, picked by the filtered sample
  function automatic seg_t seg_lookup(input logic [SampleW-1:0] a);
    seg_t s;
    if (a < 10'd277) begin
      s.slope = 9'd279;
      s.icpt  = 16'sd800;
      s.offs  = 10'd276;
    end else if (a < 10'd876) begin
      s.slope = 9'd150;
      s.icpt  = 16'sd100;
      s.offs  = 10'd875;
    end else begin
      s.slope = 9'd335;
      s.icpt  = -16'sd200;
      s.offs  = 10'd989;
    end
    return s;
  endfunction

endpackage

FILE: src/tfc_serial_mult.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on tfc_pkg.
module tfc_serial_mult (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [tfc_pkg::MulW-1:0]        mul_a,
  input  logic signed [tfc_pkg::MulW-1:0]        mul_b,
  output logic signed [2*tfc_pkg::MulW-1:0]      product,
  output tfc_pkg::mul_stat_t                     stat
);
  import tfc_pkg::*;

  logic signed [MulW-1:0] a_reg;
  logic        [MulW-1:0] hi;
  logic        [MulW-1:0] lo;
  logic        [CntW-1:0] cnt;
  logic                   busy;
  logic                   done;
  logic        [MulW:0]   addend;
  logic        [MulW:0]   sum;
  logic                   last;

  assign last = (cnt == CntW'(MulW - 1));

  always_comb begin
    addend = '0;
    if (lo[0]) begin
      // the top multiplier bit carries negative weight
      addend = last ? -{a_reg[MulW-1], a_reg} : {a_reg[MulW-1], a_reg};
    end
    sum = {hi[MulW-1], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= mul_a;
      hi    <= '0;
      lo    <= mul_b;
    end else if (busy) begin
      hi <= sum[MulW:1];
      lo <= {sum[0], lo[MulW-1:1]};
    end
  end

  assign product   = {hi, lo};
  assign stat.busy = busy;
  assign stat.done = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier restarted while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished pass");
  a_busy_len: assert property (@(posedge clk) disable iff (rst)
    (busy && last) |=> done)
    else $error("done missing after last step");

endmodule

FILE: src/thermistor_filter_temp_compensation.sv
// Top level: input filter, curve mapping, compensation sequencer, output register.
// Depends on tfc_pkg and tfc_serial_mult.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | adc_sample
//  output   | out_valid / out_ready  | temp_valid, temperature_x10,
//           |                        | position_update, new_set_position
//  config   | cfg_write_en           | cfg_index, cfg_data
//
// An in-range sample runs through the segment lookup and a pass of the shared bit-serial
// multiplier, then, with compensation on, a second pass, before it is loaded into the
// output register; an out-of-range sample goes straight to the final state. The next sample
// is taken only once the sequencer is back in idle after the load.
// A stalled output holds the sequencer in its final state until the register frees.
// Reset clears the filter, the valid flag, the configuration registers and the output handshake.
module thermistor_filter_temp_compensation (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [tfc_pkg::SampleW-1:0]    adc_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  temp_valid,
  output logic signed [tfc_pkg::TempW-1:0]      temperature_x10,
  output logic                                  position_update,
  output logic signed [tfc_pkg::RegW-1:0]       new_set_position,
  input  logic                                  cfg_write_en,
  input  logic        [tfc_pkg::IdxW-1:0]       cfg_index,
  input  logic        [tfc_pkg::RegW-1:0]       cfg_data
);
  import tfc_pkg::*;

  state_t state, state_next;

  logic signed [RegW-1:0]   comp_coefficient;
  logic signed [RegW-1:0]   base_position;
  logic signed [RegW-1:0]   base_temperature;
  logic        [FiltW-1:0]  filtered_adc;
  logic                     have_temperature;

  logic                     res_valid;
  logic signed [RegW-1:0]   res_temp;
  logic                     res_update;
  logic signed [RegW-1:0]   res_pos;
  seg_t                     seg;

  logic                     accept;
  logic                     in_range;
  logic                     mul_start;
  logic                     out_load;
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [2*MulW-1:0] product;
  mul_stat_t                mstat;

  logic        [FiltW:0]    s16;
  logic signed [FiltW:0]    diff;
  logic signed [FiltW:0]    diff_adj;
  logic        [FiltW-1:0]  filt_step;
  logic signed [RegW-1:0]   t_calc;
  logic        [23:0]       p24;
  logic        [23:0]       p24_adj;
  logic        [10:0]       offs_diff;

  assign accept   = in_valid && in_ready;
  assign in_range = (adc_sample <= SampleHigh) && (adc_sample >= SampleLow);

  // Filter step: move by a sixteenth of the difference, truncated toward zero
  always_comb begin
    s16       = {1'b0, adc_sample, 4'b0000};
    diff      = $signed(s16) - $signed({1'b0, filtered_adc});
    diff_adj  = diff[FiltW] ? diff + 15'sd15 : diff;
    filt_step = filtered_adc + FiltW'(diff_adj >>> 4);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = in_range ? ST_SEG : ST_FIN;
      ST_SEG:  state_next = ST_MUL1;
      ST_MUL1: if (mstat.done) state_next = ST_TEMP;
      ST_TEMP: state_next = (comp_coefficient != '0) ? ST_COMP : ST_FIN;
      ST_COMP: state_next = ST_MUL2;
      ST_MUL2: if (mstat.done) state_next = ST_POS;
      ST_POS:  state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SEG, ST_COMP: mul_start = 1'b1;
      ST_FIN:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign seg       = seg_lookup(filtered_adc[FiltW-1:4]);
  assign offs_diff = {1'b0, seg.offs} - {1'b0, filtered_adc[FiltW-1:4]};

  always_comb begin
    if (state == ST_SEG) begin
      mul_a = MulW'($signed(offs_diff));
      mul_b = MulW'({1'b0, seg.slope});
    end else begin
      mul_a = res_temp - base_temperature;
      mul_b = comp_coefficient;
    end
  end

  tfc_serial_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .product (product),
    .stat    (mstat)
  );

  // Bits above the shift give the floor of the quotient
  assign t_calc  = $signed(product[22:7]) + seg.icpt;
  assign p24     = product[23:0];
  assign p24_adj = p24[23] ? p24 + 24'd15 : p24;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      comp_coefficient <= '0;
      base_position    <= '0;
      base_temperature <= '0;
      filtered_adc     <= '0;
      have_temperature <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        case (cfg_index)
          RegCoef:     comp_coefficient <= cfg_data;
          RegBasePos:  base_position    <= cfg_data;
          RegBaseTemp: base_temperature <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        have_temperature <= in_range;
        if (in_range) begin
          filtered_adc <= have_temperature ? filt_step : s16[FiltW-1:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result being built
  always_ff @(posedge clk) begin
    if (accept) begin
      res_valid  <= in_range;
      res_temp   <= '0;
      res_update <= 1'b0;
      res_pos    <= '0;
    end
    if (state == ST_TEMP) begin
      res_temp <= t_calc;
    end
    if (state == ST_POS) begin
      res_update <= 1'b1;
      res_pos    <= base_position + $signed(p24_adj[19:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temp_valid       <= res_valid;
      temperature_x10  <= res_temp[TempW-1:0];
      position_update  <= res_update;
      new_set_position <= res_pos;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("sequencer stayed idle after taking a beat");
  a_update_needs_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && position_update) |-> temp_valid)
    else $error("position update on an invalid temperature");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !temp_valid) |-> (temperature_x10 == '0) && (new_set_position == '0))
    else $error("invalid result carries nonzero fields");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> (state == ST_MUL1) || (state == ST_MUL2))
    else $error("multiplier finished outside a wait state");
  a_filter_range: assert property (@(posedge clk) disable iff (rst)
    have_temperature |-> (filtered_adc[FiltW-1:4] >= SampleLow) &&
                         (filtered_adc[FiltW-1:4] <= SampleHigh))
    else $error("filter left the valid sample range");

endmodule

FILE: bench/tb_thermistor_filter_temp_compensation.sv
// Self-checking bench for the thermistor filter with focuser temperature compensation.
// Depends on tfc_pkg and thermistor_filter_temp_compensation from src.
module tb_thermistor_filter_temp_compensation;
  import tfc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 125;
  localparam int NumPhases = 8;
  localparam logic [IdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic                    tv;
    logic signed [TempW-1:0] temp;
    logic                    upd;
    logic signed [RegW-1:0]  pos;
  } temp_result_t;

  // Tracks filter state and compensation settings, predicts each result beat.
  class temp_comp_scoreboard;
    logic [FiltW-1:0]       filt;
    bit                     have_temp;
    logic signed [RegW-1:0] coef, base_pos, base_temp;
    temp_result_t           pending[$];
    int errors, checked, n_samples, n_out_range, n_comp;

    function new();
      filt = '0;
      have_temp = 0;
      coef = '0;
      base_pos = '0;
      base_temp = '0;
      errors = 0;
      checked = 0;
      n_samples = 0;
      n_out_range = 0;
      n_comp = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] data);
      case (idx)
        RegCoef:     coef = data;
        RegBasePos:  base_pos = data;
        RegBaseTemp: base_temp = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SampleW-1:0] s);
      temp_result_t           r;
      int                     diff, f, t, dt, q, slope, icpt, offs;
      logic [SampleW-1:0]     a;
      logic signed [RegW-1:0] d;
      longint                 prod;
      logic signed [23:0]     p24;
      r = '0;
      n_samples++;
      if (s > SampleHigh || s < SampleLow) begin
        // drop the valid flag, keep the filter
        have_temp = 0;
        n_out_range++;
      end else begin
        if (!have_temp) begin
          filt = {s, 4'b0000};
        end else begin
          diff = int'({s, 4'b0000}) - int'(filt);
          f = int'(filt) + diff / 16;
          filt = f[FiltW-1:0];
        end
        have_temp = 1;
        a = filt[FiltW-1:4];
        if (a < 277) begin
          slope = 279; icpt = 800; offs = 276;
        end else if (a < 876) begin
          slope = 150; icpt = 100; offs = 875;
        end else begin
          slope = 335; icpt = -200; offs = 989;
        end
        t = (((offs - int'(a)) * slope) >>> 7) + icpt;
        r.tv = 1'b1;
        r.temp = t[TempW-1:0];
        if (coef != 0) begin
          dt = t - int'(base_temp);
          d = dt[RegW-1:0];
          prod = longint'(d) * longint'(coef);
          p24 = prod[23:0];
          q = int'(p24) / 16;
          r.upd = 1'b1;
          r.pos = base_pos + q[RegW-1:0];
          n_comp++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(temp_result_t got);
      temp_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result beat with none pending (valid %0b temp %0d upd %0b pos %0d)",
                   got.tv, got.temp, got.upd, got.pos);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.tv !== want.tv || got.temp !== want.temp ||
          got.upd !== want.upd || got.pos !== want.pos) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d: valid %0b/%0b temp %0d/%0d upd %0b/%0b pos %0d/%0d",
                   checked, want.tv, got.tv, want.temp, got.temp,
                   want.upd, got.upd, want.pos, got.pos);
      end
    endfunction
  endclass

  logic                    clk, rst;
  logic                    in_valid, in_ready;
  logic [SampleW-1:0]      adc_sample;
  logic                    out_valid, out_ready;
  logic                    temp_valid, position_update;
  logic signed [TempW-1:0] temperature_x10;
  logic signed [RegW-1:0]  new_set_position;
  logic                    cfg_write_en;
  logic [IdxW-1:0]         cfg_index;
  logic [RegW-1:0]         cfg_data;

  temp_comp_scoreboard sb;
  bit quiet;
  int cycles;
  int last_ok;

  thermistor_filter_temp_compensation i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_valid(temp_valid), .temperature_x10(temperature_x10),
    .position_update(position_update), .new_set_position(new_set_position),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stall at random except during the quiet stretch.
  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    temp_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.tv = temp_valid;
      got.temp = temperature_x10;
      got.upd = position_update;
      got.pos = new_set_position;
      sb.check_result(got);
    end
  end

  task automatic push_sample(input logic [SampleW-1:0] s);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    adc_sample = s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] data);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Mostly in-range readings, often drifting slowly so the filter settles.
  function automatic logic [SampleW-1:0] pick_sample();
    int r, v;
    int edges[6] = '{16, 1008, 276, 277, 875, 876};
    r = $urandom_range(99);
    if (r < 10) begin
      v = $urandom_range(1) ? $urandom_range(15) : $urandom_range(1023, 1009);
    end else if (r < 20) begin
      v = edges[$urandom_range(5)] + $urandom_range(4) - 2;
    end else if (r < 55) begin
      v = last_ok + $urandom_range(40) - 20;
    end else begin
      v = $urandom_range(1008, 16);
    end
    if (r >= 10) begin
      if (v < 16) v = 16;
      if (v > 1008) v = 1008;
      last_ok = v;
    end
    return v[SampleW-1:0];
  endfunction

  task automatic set_phase_config(input int phase);
    case (phase)
      1: begin
        write_reg(RegCoef, 16'h7FFF);
        write_reg(RegBasePos, 16'h7FFF);
        write_reg(RegBaseTemp, 16'h8000);
        write_reg(RegSpare, 16'hBEEF);
      end
      2: begin
        write_reg(RegCoef, 16'h8000);
        write_reg(RegBasePos, 16'h8000);
        write_reg(RegBaseTemp, 16'h7FFF);
      end
      3: begin
        write_reg(RegCoef, 16'h0000);
        write_reg(RegBasePos, 16'd1234);
      end
      4: begin
        write_reg(RegCoef, 16'd16);
        write_reg(RegBasePos, 16'd0);
        write_reg(RegBaseTemp, 16'd200);
      end
      5: begin
        write_reg(RegCoef, 16'hFFFF);
        write_reg(RegBasePos, 16'hFFFF);
        write_reg(RegBaseTemp, 16'hFFFF);
      end
      default: begin
        write_reg(RegCoef, RegW'($urandom_range(65535)));
        write_reg(RegBasePos, RegW'($urandom_range(65535)));
        write_reg(RegBaseTemp, RegW'($urandom_range(1500) - 300));
      end
    endcase
  endtask

  initial begin
    logic [SampleW-1:0] directed[$];
    sb = new();
    last_ok = 512;
    quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_sample = '0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    // in-range edges, segment borders reached by reloading after an invalid beat,
    // big filter swings both ways
    directed = '{10'h000, 10'h3FF, 10'h00F, 10'h010, 10'h000, 10'd276, 10'h000,
                 10'd277, 10'h000, 10'd875, 10'h000, 10'd876, 10'h3F1, 10'h3F0,
                 10'd1000, 10'd16, 10'd16, 10'd1008, 10'h155, 10'h2AA, 10'd300,
                 10'd301};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < NumPhases; phase++) begin
      quiet = (phase == 4);
      if (phase > 0) set_phase_config(phase);
      if (phase == 1) begin
        foreach (directed[i]) push_sample(directed[i]);
      end
      repeat (ItemsPerPhase) push_sample(pick_sample());
      drain();
    end

    $display("Sent %0d samples (%0d out of range) across %0d register settings;",
             sb.n_samples, sb.n_out_range, NumPhases);
    $display("checked %0d results, %0d with compensated position, %0d mismatches.",
             sb.checked, sb.n_comp, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
